/* hdl/sha256_pkg.sv */
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenPos     = 56;
   localparam int unsigned Rounds     = 64;
   localparam logic [7:0]  PadMark    = 8'h80;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_FOLD  = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   typedef logic [31:0] word_type;

   // Working variables a..h as one group between the round unit and the sequencer.
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
      word_type f;
      word_type g;
      word_type h;
   } vars_type;

   function automatic word_type iv_word(input logic [2:0] idx);
      word_type r;
      unique case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic vars_type iv_vars();
      vars_type v;
      v.a = iv_word(3'd0); v.b = iv_word(3'd1); v.c = iv_word(3'd2); v.d = iv_word(3'd3);
      v.e = iv_word(3'd4); v.f = iv_word(3'd5); v.g = iv_word(3'd6); v.h = iv_word(3'd7);
      return v;
   endfunction

   function automatic word_type k_word(input logic [5:0] idx);
      word_type r;
      unique case (idx)
         6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
         6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
         6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
         6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
         6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
         6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
         6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
         6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
         6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
         6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
         6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
         6'd63: r = 32'hc67178f2;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hdl/sha256_round.sv */
// One SHA-256 round: schedule word update and working variable step.
module sha256_round (
   input  sha256_pkg::vars_type v,
   input  sha256_pkg::word_type k,
   input  logic                 expand,
   input  sha256_pkg::word_type w_cur,
   input  sha256_pkg::word_type w_m2,
   input  sha256_pkg::word_type w_m7,
   input  sha256_pkg::word_type w_m15,
   output sha256_pkg::word_type w_out,
   output sha256_pkg::vars_type v_out
);

   sha256_pkg::word_type s0, s1, w, ch, maj, sig0, sig1, t1, t2;

   always_comb begin
      s1 = {w_m2[16:0], w_m2[31:17]} ^ {w_m2[18:0], w_m2[31:19]} ^ (w_m2 >> 10);
      s0 = {w_m15[6:0], w_m15[31:7]} ^ {w_m15[17:0], w_m15[31:18]} ^ (w_m15 >> 3);
      w  = expand ? (s1 + w_m7 + s0 + w_cur) : w_cur;
      sig1 = {v.e[5:0], v.e[31:6]} ^ {v.e[10:0], v.e[31:11]} ^ {v.e[24:0], v.e[31:25]};
      sig0 = {v.a[1:0], v.a[31:2]} ^ {v.a[12:0], v.a[31:13]} ^ {v.a[21:0], v.a[31:22]};
      ch   = (v.e & v.f) ^ (~v.e & v.g);
      maj  = (v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c);
      t1   = v.h + sig1 + ch + k + w;
      t2   = sig0 + maj;
      w_out = w;
      v_out.a = t1 + t2;
      v_out.b = v.a;
      v_out.c = v.b;
      v_out.d = v.c;
      v_out.e = v.d + t1;
      v_out.f = v.e;
      v_out.g = v.f;
      v_out.h = v.g;
   end

endmodule

/* hdl/sha256_hash_engine.sv */
// SHA-256 hash engine. Message bytes come in one per item (req_byte_valid marks a
// real byte); an item with req_end_of_message set closes the message, after which
// the engine pads, compresses and returns eight digest words, most significant
// first, last_word set on the eighth. While idle the engine takes one item a cycle.
// The byte that fills a 64-byte block starts a compression of 64 rounds plus one
// fold step through a single shared round unit, with req_ready low throughout.
// Closing a message zero-fills one slot a cycle up to slot 55, then loads the bit
// length into the last two words and compresses the length block. When the pad
// mark lands at slot 56 or later, a zero-fill to the end of the block and an extra
// compression come first; a block filled by the closing item adds its own
// compression. The eight digest words then follow, each held while rsp_ready is
// low. The engine then returns to the initial hash state for the next message.
module sha256_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic [2:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;        // next byte slot in the block
   logic [5:0]  rnd_ff, rnd_in;
   logic [63:0] bits_ff, bits_in;
   logic        final_ff, final_in;    // compressing the length block
   logic        pad_ff, pad_in;        // message closed, padding under way
   logic        mark_ff, mark_in;      // pad mark owed to slot 0 after this block
   logic [2:0]  oidx_ff, oidx_in;
   sha256_pkg::vars_type cv_ff, cv_in, wv_ff, wv_in, v_next;
   sha256_pkg::word_type win_ff [16];
   sha256_pkg::word_type win_in [16];
   sha256_pkg::word_type w_new;

   // Shared round unit.
   sha256_round u_round (
      .v     (wv_ff),
      .k     (sha256_pkg::k_word(rnd_ff)),
      .expand(rnd_ff[5:4] != 2'd0),
      .w_cur (win_ff[rnd_ff[3:0]]),
      .w_m2  (win_ff[rnd_ff[3:0] - 4'd2]),
      .w_m7  (win_ff[rnd_ff[3:0] - 4'd7]),
      .w_m15 (win_ff[rnd_ff[3:0] - 4'd15]),
      .w_out (w_new),
      .v_out (v_next)
   );

   logic accept;
   assign req_ready = (state_ff == sha256_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == sha256_pkg::ST_OUT);

   always_comb begin
      unique case (oidx_ff)
         3'd0: rsp_digest_word = cv_ff.a;
         3'd1: rsp_digest_word = cv_ff.b;
         3'd2: rsp_digest_word = cv_ff.c;
         3'd3: rsp_digest_word = cv_ff.d;
         3'd4: rsp_digest_word = cv_ff.e;
         3'd5: rsp_digest_word = cv_ff.f;
         3'd6: rsp_digest_word = cv_ff.g;
         3'd7: rsp_digest_word = cv_ff.h;
         default: rsp_digest_word = '0;
      endcase
   end
   assign rsp_word_index = oidx_ff;
   assign rsp_last_word  = (oidx_ff == 3'd7);

   // Write one byte into the block window, clearing the word on its first byte.
   function automatic sha256_pkg::word_type put_byte(input sha256_pkg::word_type old,
                                                     input logic [1:0] lane,
                                                     input logic [7:0] b);
      sha256_pkg::word_type r;
      r = (lane == 2'd0) ? '0 : old;
      unique case (lane)
         2'd0: r[31:24] = b;
         2'd1: r[23:16] = b;
         2'd2: r[15:8]  = b;
         2'd3: r[7:0]   = b;
         default: r = old;
      endcase
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      rnd_in   = rnd_ff;
      bits_in  = bits_ff;
      final_in = final_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      oidx_in  = oidx_ff;
      cv_in    = cv_ff;
      wv_in    = wv_ff;
      win_in   = win_ff;
      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_byte_valid) begin
                  win_in[pos_ff[5:2]] = put_byte(win_ff[pos_ff[5:2]], pos_ff[1:0],
                                                 req_data_byte);
                  bits_in = bits_ff + 64'd8;
                  pos_in  = pos_ff + 6'd1;
               end
               if (req_end_of_message) begin
                  pad_in = 1'b1;
                  if (req_byte_valid && pos_ff == 6'd63) begin
                     // Block just filled: owe the pad mark to the next block.
                     mark_in = 1'b1;
                  end else begin
                     // Place the pad mark into the slot after any byte of this item.
                     win_in[pos_in[5:2]] = put_byte(win_in[pos_in[5:2]], pos_in[1:0],
                                                    sha256_pkg::PadMark);
                     pos_in = pos_in + 6'd1;
                  end
               end
               // A wrapped slot counter means the block is full: compress it now.
               if ((req_byte_valid || req_end_of_message) && pos_in == 6'd0) begin
                  state_in = sha256_pkg::ST_ROUND;
                  wv_in    = cv_ff;
                  rnd_in   = '0;
               end else if (req_end_of_message) begin
                  state_in = sha256_pkg::ST_PAD;
               end
            end
         end
         sha256_pkg::ST_ROUND: begin
            win_in[rnd_ff[3:0]] = w_new;
            wv_in  = v_next;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'(sha256_pkg::Rounds - 1))
               state_in = sha256_pkg::ST_FOLD;
         end
         sha256_pkg::ST_FOLD: begin
            cv_in.a = cv_ff.a + wv_ff.a; cv_in.b = cv_ff.b + wv_ff.b;
            cv_in.c = cv_ff.c + wv_ff.c; cv_in.d = cv_ff.d + wv_ff.d;
            cv_in.e = cv_ff.e + wv_ff.e; cv_in.f = cv_ff.f + wv_ff.f;
            cv_in.g = cv_ff.g + wv_ff.g; cv_in.h = cv_ff.h + wv_ff.h;
            if (final_ff) begin
               state_in = sha256_pkg::ST_OUT;
               oidx_in  = '0;
            end else if (pad_ff) begin
               // Carry on padding in a fresh block; drop in the owed pad mark first.
               state_in = sha256_pkg::ST_PAD;
               if (mark_ff) begin
                  win_in[0] = put_byte(win_ff[0], 2'd0, sha256_pkg::PadMark);
                  pos_in    = 6'd1;
                  mark_in   = 1'b0;
               end
            end else begin
               state_in = sha256_pkg::ST_IDLE;
            end
         end
         sha256_pkg::ST_PAD: begin
            // Zero-fill one slot a cycle; wrap through an extra block when past the length field.
            if (pos_ff == 6'(sha256_pkg::LenPos) && !final_ff) begin
               win_in[14] = bits_ff[63:32];
               win_in[15] = bits_ff[31:0];
               pos_in     = '0;
               final_in   = 1'b1;
               state_in   = sha256_pkg::ST_ROUND;
               wv_in      = cv_ff;
               rnd_in     = '0;
            end else begin
               win_in[pos_ff[5:2]] = put_byte(win_ff[pos_ff[5:2]], pos_ff[1:0], 8'h00);
               pos_in = pos_ff + 6'd1;
               if (pos_ff == 6'd63) begin
                  state_in = sha256_pkg::ST_ROUND;
                  wv_in    = cv_ff;
                  rnd_in   = '0;
               end
            end
         end
         sha256_pkg::ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_in = sha256_pkg::ST_IDLE;
                  cv_in    = sha256_pkg::iv_vars();
                  bits_in  = '0;
                  pos_in   = '0;
                  final_in = 1'b0;
                  pad_in   = 1'b0;
                  mark_in  = 1'b0;
               end
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         pos_ff   <= '0;
         rnd_ff   <= '0;
         bits_ff  <= '0;
         final_ff <= 1'b0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         oidx_ff  <= '0;
         cv_ff    <= sha256_pkg::iv_vars();
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         rnd_ff   <= rnd_in;
         bits_ff  <= bits_in;
         final_ff <= final_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         oidx_ff  <= oidx_in;
         cv_ff    <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      wv_ff  <= wv_in;
      win_ff <= win_in;
   end

   // Hold the digest word while the consumer stalls.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_index))
      else $error("digest word moved under stall");
   // The fold step is only ever entered from the round state.
   a_rnd: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha256_pkg::ST_FOLD |-> $past(state_ff) == sha256_pkg::ST_ROUND)
      else $error("fold without rounds");
   // No input taken while busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != sha256_pkg::ST_IDLE |-> !req_ready)
      else $error("ready while busy");

endmodule

/* verif/sha256_digest_checker.sv */
module sha256_digest_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_digest_word,
   input  logic [2:0]  rsp_word_index,
   input  logic        rsp_last_word,
   output int          fail_count,
   output int          pending_words,
   output int          digests_seen
);

   typedef struct packed {
      sha256_pkg::word_type digest_word;
      logic [2:0]           word_index;
      logic                 last_word;
   } digest_item_type;

   localparam sha256_pkg::word_type KTAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam sha256_pkg::word_type HINIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   sha256_pkg::word_type hstate [8];
   sha256_pkg::word_type blk [16];
   logic [63:0]          bit_len;
   logic [6:0]           fill;
   digest_item_type      exp_fifo [16];
   logic [3:0]           wr_ptr, rd_ptr;
   int                   exp_count = 0;

   function automatic sha256_pkg::word_type ror(sha256_pkg::word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic place_byte(input logic [5:0] pos, input logic [7:0] b);
      sha256_pkg::word_type sh;
      sh = sha256_pkg::word_type'(b) << (8 * (3 - pos[1:0]));
      if (pos[1:0] == 2'd0) begin
         blk[pos[5:2]] = sh;
      end else begin
         blk[pos[5:2]] |= sh;
      end
   endtask

   task automatic compress();
      sha256_pkg::word_type v [8];
      sha256_pkg::word_type w, t1, t2, s0, s1;
      for (int j = 0; j < 8; j++) v[j] = hstate[j];
      for (int t = 0; t < 64; t++) begin
         if (t >= 16) begin
            s1 = ror(blk[(t-2)%16], 17) ^ ror(blk[(t-2)%16], 19) ^ (blk[(t-2)%16] >> 10);
            s0 = ror(blk[(t-15)%16], 7) ^ ror(blk[(t-15)%16], 18) ^ (blk[(t-15)%16] >> 3);
            blk[t%16] = s1 + blk[(t-7)%16] + s0 + blk[t%16];
         end
         w  = blk[t%16];
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w;
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int j = 7; j > 0; j--) v[j] = v[j-1];
         v[4] += t1;
         v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) hstate[j] += v[j];
   endtask

   task automatic absorb_item(input logic [7:0] b, input logic bv, input logic eom);
      int pos;
      digest_item_type d;
      if (bv) begin
         place_byte(fill[5:0], b);
         bit_len += 64'd8;
         fill++;
         if (fill >= 7'd64) begin
            compress();
            fill = '0;
         end
      end
      if (!eom) return;
      pos = int'(fill[5:0]);
      place_byte(6'(pos), sha256_pkg::PadMark);
      pos++;
      if (pos > sha256_pkg::LenPos) begin
         for (; pos < sha256_pkg::BlockBytes; pos++) place_byte(6'(pos), 8'h00);
         compress();
         pos = 0;
      end
      for (; pos < sha256_pkg::LenPos; pos++) place_byte(6'(pos), 8'h00);
      blk[14] = bit_len[63:32];
      blk[15] = bit_len[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
         d.digest_word = hstate[i];
         d.word_index  = 3'(i);
         d.last_word   = (i == 7);
         exp_fifo[wr_ptr] = d;
         wr_ptr = wr_ptr + 4'd1;
         exp_count++;
      end
      for (int j = 0; j < 8; j++) hstate[j] = HINIT[j];
      bit_len = '0;
      fill    = '0;
   endtask

   assign pending_words = exp_count;

   always @(posedge clock) begin
      digest_item_type e;
      if (reset) begin
         for (int j = 0; j < 8; j++) hstate[j] = HINIT[j];
         for (int j = 0; j < 16; j++) blk[j] = '0;
         bit_len   = '0;
         fill      = '0;
         wr_ptr    = '0;
         rd_ptr    = '0;
         exp_count = 0;
         fail_count   <= 0;
         digests_seen <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (exp_count == 0) begin
               $error("unexpected digest word %h", rsp_digest_word);
               fail_count <= fail_count + 1;
            end else begin
               e = exp_fifo[rd_ptr];
               rd_ptr = rd_ptr + 4'd1;
               exp_count--;
               if (rsp_digest_word !== e.digest_word || rsp_word_index !== e.word_index
                   || rsp_last_word !== e.last_word) begin
                  if (rsp_digest_word !== e.digest_word)
                     $error("digest_word exp %h got %h", e.digest_word, rsp_digest_word);
                  if (rsp_word_index !== e.word_index)
                     $error("word_index exp %0d got %0d", e.word_index, rsp_word_index);
                  if (rsp_last_word !== e.last_word)
                     $error("last_word exp %0d got %0d", e.last_word, rsp_last_word);
                  fail_count <= fail_count + 1;
               end
               if (e.last_word) digests_seen <= digests_seen + 1;
            end
         end
         if (req_valid && req_ready)
            absorb_item(req_data_byte, req_byte_valid, req_end_of_message);
      end
   end
endmodule

/* verif/sha256_hash_engine_tb.sv */
module sha256_hash_engine_tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_byte_valid = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;
   int          fail_count, pending_words, digests_seen;
   int          items_sent = 0;
   int          idle_cycles = 0;
   int          sink_gap = 0;        // cycles left in a receiver idle burst
   bit          quiet_tail = 1'b0;   // no idling on either side near the end
   bit          hold_sink = 1'b0;    // long receiver stall in progress
   bit          run_done = 1'b0;

   localparam int WATCHDOG = 20000;

   always #6 clock = ~clock;

   sha256_hash_engine dut (.*);

   sha256_digest_checker chk (.*);

   // Send one item: raise valid at the edge, hold until the handshake, optionally idle after.
   task automatic send_item(input logic [7:0] b, input logic bv, input logic eom);
      int gap;
      req_valid          <= 1'b1;
      req_data_byte      <= b;
      req_byte_valid     <= bv;
      req_end_of_message <= eom;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      // Idle in bursts now and then, otherwise keep valid high for the next item.
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A message of n random bytes; the close may come on the last byte or on a bare item.
   task automatic send_message(input int n);
      bit fused;
      fused = (n > 0) && $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);  // filler
         send_item(8'($urandom), 1'b1, fused && (i == n - 1));
      end
      if (!fused) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // Receiver: random idle bursts, plus one long hold while the sender keeps going.
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         rsp_ready <= !reset;
         sink_gap  <= 0;
      end else if (hold_sink) begin
         rsp_ready <= 1'b0;
      end else if (sink_gap > 0) begin
         rsp_ready <= 1'b0;
         sink_gap  <= sink_gap - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         sink_gap  <= $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      int stall;
      @(posedge clock);
      wait (!reset);
      wait (digests_seen >= 3);
      hold_sink = 1'b1;
      for (stall = 0; stall < 600; stall++) @(posedge clock);
      hold_sink = 1'b0;
   end

   // Watchdog: count cycles with no handshake on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!run_done && idle_cycles >= WATCHDOG) begin
         $display("watchdog expired after %0d items", items_sent);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: empty message, extremes of byte values, no-op item, boundary lengths.
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);      // ignored item
      send_item(8'hff, 1'b0, 1'b1);      // close only: message is a single 0x00 byte
      send_item(8'h5a, 1'b0, 1'b1);      // empty message
      send_item(8'hff, 1'b1, 1'b1);      // one byte 0xff, closed on the byte
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);      // "abc"
      send_item(8'haa, 1'b0, 1'b1);      // empty again after a digest
      send_message(55);                  // padding fits one block
      send_message(56);                  // padding spills into an extra block
      send_message(63);
      send_message(64);                  // exactly one block, then a padding block
      // Random: mostly short messages, an occasional multi-block one.
      while (items_sent < 280) begin
         if ($urandom_range(0, 7) == 0) send_message($urandom_range(57, 140));
         else send_message($urandom_range(0, 20));
      end
      quiet_tail = 1'b1;
      send_message($urandom_range(1, 70));
      send_message(0);
      req_valid <= 1'b0;
      wait (pending_words == 0);
      repeat (200) @(posedge clock);
      run_done = 1'b1;
      $display("%0d items sent, %0d digests checked, including empty and block-edge messages",
                items_sent, digests_seen);
      if (fail_count == 0 && pending_words == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
